### rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stereo feedback echo core.
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int STORE_DEPTH_DEF = 65536;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int FILT_EXTRA = 8;       // extra fraction bits in filter state
	localparam int Q15_SHIFT  = 15;
	localparam int FB_SHIFT   = 23;      // Q15_SHIFT + FILT_EXTRA
	localparam int ROUND_Q15  = 16384;   // half an LSB before a shift by 15
	localparam int ROUND_FB   = 4194304; // half an LSB before a shift by 23
	localparam int UNITY_Q15  = 32768;

	localparam int GEN_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 2'd3;

	localparam logic [15:0] DELAY_LENGTH_RST  = 16'd22050;
	localparam logic [14:0] FEEDBACK_GAIN_RST = 15'd0;
	localparam logic [15:0] DAMPING_COEFF_RST = 16'd32768;
	localparam logic [15:0] WET_GAIN_RST      = 16'd0;

	typedef struct packed {
		logic               restart;
		logic signed [15:0] dry_left;
		logic signed [15:0] dry_right;
	} sfe_in_t;

	typedef struct packed {
		logic signed [15:0] wet_left;
		logic signed [15:0] wet_right;
	} sfe_out_t;

	// Step strobes from the controller to the datapath
	typedef struct packed {
		logic accept;  // item taken, memory read issued
		logic load;    // capture delayed samples
		logic mul1;    // filter and wet products
		logic upd;     // filter state update
		logic mul2;    // feedback product
		logic write;   // write back, present result
		logic clear;   // tag clearing pass
	} sfe_cmd_t;

	typedef struct packed {
		logic clear_last;
	} sfe_sts_t;

endpackage

### rtl/sfe_ram.sv
// ----------------------------------------------------------------------------
// sfe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/sfe_lane.sv
// ----------------------------------------------------------------------------
// sfe_lane
// Per-channel arithmetic: damping filter, feedback sum and wet gain.
// ----------------------------------------------------------------------------
module sfe_lane #(
	parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfe_pkg::sfe_cmd_t      cmd,
	input  logic                   filt_clr,
	input  logic                   tag_ok,
	input  logic [SAMPLE_BITS-1:0] rd_sample,
	input  logic signed [15:0]     dry,
	input  logic [16:0]            coeff,
	input  logic [14:0]            fb_gain,
	input  logic [15:0]            wet_gain,
	output logic [SAMPLE_BITS-1:0] store_val,
	output logic signed [15:0]     wet
);

	localparam int SB   = SAMPLE_BITS;
	localparam int FW   = SB + sfe_pkg::FILT_EXTRA;
	localparam int DW   = FW + 1;
	localparam int PW   = DW + 18;
	localparam int WPW  = SB + 17;
	localparam int FPW  = FW + 16;
	localparam int SUMW = FPW + 1;

	localparam logic signed [WPW-1:0]  W_MAX = WPW'(32767);
	localparam logic signed [WPW-1:0]  W_MIN = WPW'(-32768);
	localparam logic signed [SUMW-1:0] S_MAX = {{(SUMW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [SUMW-1:0] S_MIN = {{(SUMW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	logic signed [SB-1:0]   delayed_q;
	logic signed [FW-1:0]   filt_q;
	logic signed [PW-1:0]   cprod_q;
	logic signed [WPW-1:0]  wprod_q;
	logic signed [FPW-1:0]  fprod_q;

	logic signed [DW-1:0]   diff;
	logic signed [PW-1:0]   c_rnd;
	logic signed [PW-1:0]   c_step;
	logic signed [FW-1:0]   filt_next;
	logic signed [WPW-1:0]  w_rnd;
	logic signed [WPW-1:0]  w_sh;
	logic signed [FPW-1:0]  f_rnd;
	logic signed [FPW-1:0]  fbk;
	logic signed [SUMW-1:0] sum;

	assign diff      = (DW'(delayed_q) <<< sfe_pkg::FILT_EXTRA) - DW'(filt_q);
	assign c_rnd     = cprod_q + PW'(sfe_pkg::ROUND_Q15);
	assign c_step    = c_rnd >>> sfe_pkg::Q15_SHIFT;
	assign filt_next = filt_q + $signed(c_step[FW-1:0]);
	assign w_rnd     = wprod_q + WPW'(sfe_pkg::ROUND_Q15);
	assign w_sh      = w_rnd >>> sfe_pkg::Q15_SHIFT;
	assign f_rnd     = fprod_q + FPW'(sfe_pkg::ROUND_FB);
	assign fbk       = f_rnd >>> sfe_pkg::FB_SHIFT;
	assign sum       = SUMW'(fbk) + SUMW'(dry);

	always_comb begin
		if (w_sh > W_MAX) begin
			wet = 16'sh7fff;
		end else if (w_sh < W_MIN) begin
			wet = 16'sh8000;
		end else begin
			wet = w_sh[15:0];
		end
	end

	always_comb begin
		if (sum > S_MAX) begin
			store_val = S_MAX[SB-1:0];
		end else if (sum < S_MIN) begin
			store_val = S_MIN[SB-1:0];
		end else begin
			store_val = sum[SB-1:0];
		end
	end

	// filter state: cleared on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (filt_clr) begin
			filt_q <= '0;
		end else if (cmd.upd) begin
			filt_q <= filt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delayed_q <= tag_ok ? $signed(rd_sample) : '0;
		end
		if (cmd.mul1) begin
			cprod_q <= $signed({1'b0, coeff}) * diff;
			wprod_q <= delayed_q * $signed({1'b0, wet_gain});
		end
		if (cmd.mul2) begin
			fprod_q <= $signed({1'b0, fb_gain}) * filt_q;
		end
	end

endmodule

### rtl/sfe_dpath.sv
// ----------------------------------------------------------------------------
// sfe_dpath
// Datapath: settings, pointers, tag and sample memories, both lanes.
// ----------------------------------------------------------------------------
module sfe_dpath #(
	parameter int STORE_DEPTH = sfe_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfe_pkg::sfe_cmd_t                cmd,
	output sfe_pkg::sfe_sts_t                sts,
	input  sfe_pkg::sfe_in_t                 in_data,
	input  logic                             cfg_we,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfe_pkg::sfe_out_t                out_data
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int DLW = (AW > 16) ? AW : 16;
	localparam int GW  = sfe_pkg::GEN_W;

	logic [15:0]            delay_q;
	logic [14:0]            fb_gain_q;
	logic [15:0]            damp_q;
	logic [15:0]            wet_gain_q;
	logic [GW-1:0]          gen_q;
	logic [GW-1:0]          gen_inc;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          clr_cnt_q;
	logic signed [15:0]     dry_l_q;
	logic signed [15:0]     dry_r_q;
	sfe_pkg::sfe_out_t      out_q;

	logic [AW-1:0]          wp_eff;
	logic [DLW-1:0]         d_ext;
	logic [DLW-1:0]         d_clamp;
	logic [AW-1:0]          d_eff;
	logic [AW:0]            rd_sum;
	logic [AW-1:0]          rd_addr;
	logic [16:0]            coeff;
	logic                   filt_clr;

	logic [GW-1:0]          tag_rd;
	logic                   tag_ok;
	logic                   tag_we;
	logic [AW-1:0]          tag_waddr;
	logic [GW-1:0]          tag_wdata;
	logic [2*SAMPLE_BITS-1:0] smp_rd;
	logic [SAMPLE_BITS-1:0] store_l;
	logic [SAMPLE_BITS-1:0] store_r;
	logic signed [15:0]     wet_l;
	logic signed [15:0]     wet_r;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= sfe_pkg::DELAY_LENGTH_RST;
			fb_gain_q  <= sfe_pkg::FEEDBACK_GAIN_RST;
			damp_q     <= sfe_pkg::DAMPING_COEFF_RST;
			wet_gain_q <= sfe_pkg::WET_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfe_pkg::REG_DELAY_LENGTH:  delay_q    <= cfg_data;
				sfe_pkg::REG_FEEDBACK_GAIN: fb_gain_q  <= cfg_data[14:0];
				sfe_pkg::REG_DAMPING_COEFF: damp_q     <= cfg_data;
				sfe_pkg::REG_WET_GAIN:      wet_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coeff = (damp_q > 16'(sfe_pkg::UNITY_Q15)) ? 17'(sfe_pkg::UNITY_Q15)
		: {1'b0, damp_q};

	// read address: clamp distance, wrap behind the writer
	assign wp_eff = in_data.restart ? '0 : wp_q;
	assign d_ext  = DLW'(delay_q);

	always_comb begin
		if (d_ext == '0) begin
			d_clamp = DLW'(1);
		end else if (d_ext > DLW'(STORE_DEPTH - 1)) begin
			d_clamp = DLW'(STORE_DEPTH - 1);
		end else begin
			d_clamp = d_ext;
		end
	end

	assign d_eff   = d_clamp[AW-1:0];
	assign rd_sum  = (wp_eff >= d_eff) ? ({1'b0, wp_eff} - {1'b0, d_eff})
		: ({1'b0, wp_eff} + (AW+1)'(STORE_DEPTH) - {1'b0, d_eff});
	assign rd_addr = rd_sum[AW-1:0];

	assign gen_inc  = gen_q + GW'(1);
	assign filt_clr = cmd.accept & in_data.restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q     <= GW'(1);
			wp_q      <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (filt_clr) begin
				gen_q <= (gen_inc == '0) ? GW'(1) : gen_inc;
				wp_q  <= '0;
			end else if (cmd.write) begin
				wp_q <= (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	assign sts.clear_last = (clr_cnt_q == AW'(STORE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dry_l_q <= in_data.dry_left;
			dry_r_q <= in_data.dry_right;
		end
		if (cmd.write) begin
			out_q.wet_left  <= wet_l;
			out_q.wet_right <= wet_r;
		end
	end

	assign out_data = out_q;

	// tag memory: zeroed by the clearing pass, then written with the generation
	assign tag_we    = cmd.clear | cmd.write;
	assign tag_waddr = cmd.clear ? clr_cnt_q : wp_q;
	assign tag_wdata = cmd.clear ? '0 : gen_q;
	assign tag_ok    = (tag_rd == gen_q);

	sfe_ram #(
		.WIDTH (GW),
		.DEPTH (STORE_DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	sfe_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_smp_ram (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (wp_q),
		.wdata ({store_l, store_r}),
		.re    (cmd.accept),
		.raddr (rd_addr),
		.rdata (smp_rd)
	);

	sfe_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.filt_clr  (filt_clr),
		.tag_ok    (tag_ok),
		.rd_sample (smp_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.dry       (dry_l_q),
		.coeff     (coeff),
		.fb_gain   (fb_gain_q),
		.wet_gain  (wet_gain_q),
		.store_val (store_l),
		.wet       (wet_l)
	);

	sfe_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.filt_clr  (filt_clr),
		.tag_ok    (tag_ok),
		.rd_sample (smp_rd[SAMPLE_BITS-1:0]),
		.dry       (dry_r_q),
		.coeff     (coeff),
		.fb_gain   (fb_gain_q),
		.wet_gain  (wet_gain_q),
		.store_val (store_r),
		.wet       (wet_r)
	);

endmodule

### rtl/sfe_ctrl.sv
// ----------------------------------------------------------------------------
// sfe_ctrl
// Controller: clearing pass, per-item step sequence, result handshake.
// ----------------------------------------------------------------------------
module sfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sfe_pkg::sfe_cmd_t cmd,
	input  sfe_pkg::sfe_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MUL1,
		ST_UPD,
		ST_MUL2,
		ST_WR
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.accept = in_valid & in_ready;
	assign cmd.load   = (state_q == ST_LOAD);
	assign cmd.mul1   = (state_q == ST_MUL1);
	assign cmd.upd    = (state_q == ST_UPD);
	assign cmd.mul2   = (state_q == ST_MUL2);
	// hold write-back until the output register is free
	assign cmd.write  = (state_q == ST_WR) & (~out_valid_q | out_ready);
	assign cmd.clear  = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_WR;
				ST_WR: begin
					if (cmd.write) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/stereo_feedback_echo_core.sv
// ----------------------------------------------------------------------------
// stereo_feedback_echo_core
// Stereo feedback echo with a damped feedback path, one sample pair per item.
// ----------------------------------------------------------------------------
// Each item carries one dry stereo pair and a restart flag; each item yields
// exactly one wet pair. After reset the core zeroes the generation tag
// memory (one entry a cycle) and takes no item until that pass is done;
// configuration writes are accepted throughout. From then on an item runs
// through its steps in order after its acceptance: the memory read, then the
// dependent chain of filter multiply, filter update and feedback multiply in
// each channel lane, then the write-back. The next item can be taken in the
// cycle after write-back, so no item is taken while another is in its steps.
// The result lands in an output register, so a new item is taken while an
// earlier result still waits; the write-back of an item stalls only if the
// previous result has not been taken.
// Settings (delay, feedback, damping, wet gain) must be written while idle.
// ----------------------------------------------------------------------------
module stereo_feedback_echo_core #(
	parameter int STORE_DEPTH = sfe_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// dry item in
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sfe_pkg::sfe_in_t               in_data,
	// wet item out
	output logic                           out_valid,
	input  logic                           out_ready,
	output sfe_pkg::sfe_out_t              out_data,
	// settings write port
	input  logic                           cfg_we,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data
);

	// step strobes down, clearing-pass status up
	sfe_pkg::sfe_cmd_t cmd;
	sfe_pkg::sfe_sts_t sts;

	sfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// memories, pointers, generation counter and the two channel lanes
	sfe_dpath #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

### rtl/sfe_checker.sv
// ----------------------------------------------------------------------------
// sfe_checker
// Port-level checks for the stereo feedback echo core, bound to the top level.
// ----------------------------------------------------------------------------
module sfe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input sfe_pkg::sfe_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input sfe_pkg::sfe_out_t out_data
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// a stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while stalled");

	// an item keeps the core busy from its load step through its feedback multiply
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("item taken while another is in progress");

	// a new result only comes out of write-back, never from idle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in progress");

endmodule

bind stereo_feedback_echo_core sfe_checker u_sfe_checker (.*);
